// ===== rtl/core/mmdma_pkg.sv =====
// ---------------------------------------------------------------------------
// Memory map decoder package
// Shared constants and types for the memory map decoder with object RAM DMA.
// ---------------------------------------------------------------------------
`default_nettype none
package mmdma_pkg;
    localparam int ObjBytes = 160;
    localparam int BootBytes = 256;
    localparam int TicksPerDmaByte = 4;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    localparam logic [2:0] TGT_INT   = 3'd0;
    localparam logic [2:0] TGT_CART  = 3'd1;
    localparam logic [2:0] TGT_VIDEO = 3'd2;
    localparam logic [2:0] TGT_TIMER = 3'd3;
    localparam logic [2:0] TGT_JOY   = 3'd4;

    // Store selected by a decoded address.
    typedef enum logic [3:0] {
        SRC_EXT   = 4'd0,
        SRC_BOOT  = 4'd1,
        SRC_VRAM  = 4'd2,
        SRC_WRAM  = 4'd3,
        SRC_OAM   = 4'd4,
        SRC_IOF   = 4'd5,
        SRC_IFLAG = 4'd6,
        SRC_HRAM  = 4'd7,
        SRC_IE    = 4'd8,
        SRC_FF    = 4'd9
    } t_src;

    typedef struct packed {
        t_src        src;
        logic [2:0]  tgt;
        logic [12:0] idx;
    } t_dec;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  wdata;
        logic [7:0]  ext_rdata;
    } t_in;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [2:0]  target;
        logic        ext_write;
        logic [7:0]  ext_wdata;
        logic        dma_busy;
        logic [15:0] dma_next_address;
        logic [2:0]  dma_next_target;
        logic        dma_copied;
    } t_out;

    function automatic t_dec f_decode(input logic [15:0] a, input logic boot_en);
        t_dec d;
        logic [15:0] o;
        d.src = SRC_FF;
        d.tgt = TGT_INT;
        d.idx = 13'd0;
        o = a - 16'hFF80;
        if (a <= 16'h7FFF) begin
            if (boot_en && a <= 16'h00FF && 32'(a) < BootBytes) begin
                d.src = SRC_BOOT;
                d.idx = 13'(a[7:0]);
            end else begin
                d.src = SRC_EXT;
                d.tgt = TGT_CART;
            end
        end else if (a <= 16'h9FFF) begin
            d.src = SRC_VRAM;
            d.idx = a[12:0];
        end else if (a <= 16'hBFFF) begin
            d.src = SRC_EXT;
            d.tgt = TGT_CART;
        end else if (a <= 16'hFDFF) begin
            d.src = SRC_WRAM;
            d.idx = a[12:0];
        end else if (a <= 16'hFE9F) begin
            if (32'(a[7:0]) < ObjBytes) begin
                d.src = SRC_OAM;
                d.idx = 13'(a[7:0]);
            end
        end else if (a <= 16'hFEFF) begin
            d.src = SRC_FF;
        end else if (a <= 16'hFF7F) begin
            if (a == 16'hFF00) begin
                d.src = SRC_EXT;
                d.tgt = TGT_JOY;
            end else if (a >= 16'hFF04 && a <= 16'hFF07) begin
                d.src = SRC_EXT;
                d.tgt = TGT_TIMER;
            end else if (a == 16'hFF0F) begin
                d.src = SRC_IFLAG;
                d.idx = 13'h0F;
            end else if (a >= 16'hFF40 && a <= 16'hFF4B) begin
                d.src = SRC_EXT;
                d.tgt = TGT_VIDEO;
            end else if (a >= 16'hFF10 && a <= 16'hFF3F) begin
                d.src = SRC_IOF;
                d.idx = 13'(a[6:0]);
            end
        end else if (a <= 16'hFFFE) begin
            d.src = SRC_HRAM;
            d.idx = 13'(o[6:0]);
        end else begin
            d.src = SRC_IE;
        end
        return d;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mmdma_if.sv =====
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word.
// ---------------------------------------------------------------------------
`default_nettype none
interface mmdma_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/memory_map_decoder_with_oam_dma_top.sv =====
// ---------------------------------------------------------------------------
// Memory map decoder with object RAM DMA
// Decodes byte accesses, serves on-chip stores and runs the object copy.
// ---------------------------------------------------------------------------
// Input channel i_in carries action, address, wdata and ext_rdata; output
// channel o_out carries one result word per input word.
// An item is taken in a read cycle (store read from the synchronous RAMs)
// and finished in an execute cycle that writes back and fills the output
// register; the take in ST_IDLE leads to ST_EXEC and then to ST_OUT, which
// offers the result word. One item is handled at a time: read, execute and
// the output handshake; the next word is taken after the handshake.
// The read/modify/write of the shared RAM port is why items do not overlap.
// After reset a clearing pass sweeps all RAMs but the boot RAM, one entry per
// cycle, during which no input word is taken.
// When the receiver stalls the result is held and no new word is taken
// until the output register empties.
// ---------------------------------------------------------------------------
`default_nettype none
module memory_map_decoder_with_oam_dma_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mmdma_if.sink     i_in,
    mmdma_if.source   o_out
);
    import mmdma_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    logic [7:0] vram [8192];
    logic [7:0] wram [8192];
    logic [7:0] oam  [160];
    logic [7:0] hram [127];
    logic [7:0] iof  [128];
    logic [7:0] boot [256];

    t_state      r_state, n_state;
    logic [13:0] r_clr;
    t_in         r_in;
    t_out        r_out;
    logic        r_boot_en;
    logic [7:0]  r_ie;
    logic        r_dma_act;
    logic [7:0]  r_dma_page;
    logic [7:0]  r_dma_idx;
    logic [1:0]  r_dma_ph;
    logic [7:0]  r_rd;
    t_dec        r_dec;

    t_in   w_in;
    t_dec  w_dec;
    logic  w_copy;
    logic [15:0] w_src;
    logic [15:0] w_addr;
    logic  w_take;

    assign w_in = t_in'(i_in.data);
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_take = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == ST_OUT);
    assign o_out.data = r_out;

    // A copying tick reads the DMA source, everything else the bus address.
    assign w_copy = (w_in.action == ACT_TICK) && r_dma_act &&
                    (32'(r_dma_ph) + 1 >= TicksPerDmaByte);
    assign w_src  = {r_dma_page, r_dma_idx};
    assign w_addr = w_copy ? w_src : w_in.address;
    assign w_dec  = f_decode(w_addr, r_boot_en);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == 14'd8191) n_state = ST_IDLE;
            ST_IDLE:  if (w_take) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_OUT;
            ST_OUT:   if (o_out.ready) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Store read port: one registered read per item.
    always_ff @(posedge i_clk) begin
        case (w_dec.src)
            SRC_BOOT:  r_rd <= boot[w_dec.idx[7:0]];
            SRC_VRAM:  r_rd <= vram[w_dec.idx];
            SRC_WRAM:  r_rd <= wram[w_dec.idx];
            SRC_OAM:   r_rd <= oam[w_dec.idx[7:0]];
            SRC_IOF:   r_rd <= iof[w_dec.idx[6:0]];
            SRC_IFLAG: r_rd <= iof[7'h0F] | 8'hE0;
            SRC_HRAM:  r_rd <= hram[w_dec.idx[6:0]];
            default:   r_rd <= 8'h00;
        endcase
        if (w_take) begin
            r_in  <= w_in;
            r_dec <= w_dec;
        end
    end

    logic [7:0]  w_byte;
    logic        w_cp;
    logic [15:0] w_a;

    always_comb begin
        case (r_dec.src)
            SRC_EXT: w_byte = r_in.ext_rdata;
            SRC_IE:  w_byte = r_ie;
            SRC_FF:  w_byte = 8'hFF;
            default: w_byte = r_rd;
        endcase
        w_cp = (r_in.action == ACT_TICK) && r_dma_act &&
               (32'(r_dma_ph) + 1 >= TicksPerDmaByte);
        w_a  = r_in.address;
    end

    // Execute: write back and form the result.
    logic [7:0] w_nidx;
    logic       w_nact;
    logic [7:0] w_npage;
    t_dec       w_ndec;

    always_comb begin
        w_nidx  = r_dma_idx;
        w_nact  = r_dma_act;
        w_npage = r_dma_page;
        if (r_in.action == ACT_WRITE && w_a == 16'hFF46) begin
            w_nidx  = 8'd0;
            w_nact  = 1'b1;
            w_npage = r_in.wdata;
        end else if (w_cp) begin
            w_nidx = r_dma_idx + 8'd1;
            if (32'(w_nidx) >= ObjBytes) w_nact = 1'b0;
        end
        w_ndec = f_decode({w_npage, w_nidx}, r_boot_en &&
                 !(r_in.action == ACT_WRITE && w_a == 16'hFF50));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            vram[r_clr[12:0]] <= 8'h00;
            wram[r_clr[12:0]] <= 8'h00;
            if (r_clr < 14'd160) oam[r_clr[7:0]] <= 8'h00;
            if (r_clr < 14'd127) hram[r_clr[6:0]] <= 8'h00;
            if (r_clr < 14'd128) iof[r_clr[6:0]] <= 8'h00;
        end else if (r_state == ST_EXEC) begin
            r_out.rdata      <= 8'h00;
            r_out.target     <= TGT_INT;
            r_out.ext_write  <= 1'b0;
            r_out.ext_wdata  <= 8'h00;
            r_out.dma_copied <= 1'b0;
            case (t_action'(r_in.action))
                ACT_READ: begin
                    r_out.rdata  <= w_byte;
                    r_out.target <= r_dec.tgt;
                end
                ACT_WRITE: begin
                    case (r_dec.src)
                        SRC_VRAM: vram[r_dec.idx] <= r_in.wdata;
                        SRC_WRAM: wram[r_dec.idx] <= r_in.wdata;
                        SRC_OAM:  oam[r_dec.idx[7:0]] <= r_in.wdata;
                        SRC_HRAM: hram[r_dec.idx[6:0]] <= r_in.wdata;
                        default: ;
                    endcase
                    // ROM writes go to the cartridge even under the boot overlay
                    if (w_a <= 16'h7FFF || (w_a >= 16'hA000 && w_a <= 16'hBFFF)) begin
                        r_out.target    <= TGT_CART;
                        r_out.ext_write <= 1'b1;
                        r_out.ext_wdata <= r_in.wdata;
                    end else if (w_a >= 16'hFF00 && w_a <= 16'hFF7F) begin
                        if (w_a == 16'hFF00) begin
                            r_out.target    <= TGT_JOY;
                            r_out.ext_write <= 1'b1;
                            r_out.ext_wdata <= r_in.wdata;
                        end else if (w_a >= 16'hFF04 && w_a <= 16'hFF07) begin
                            r_out.target    <= TGT_TIMER;
                            r_out.ext_write <= 1'b1;
                            r_out.ext_wdata <= (w_a == 16'hFF04) ? 8'h00 : r_in.wdata;
                        end else if (w_a == 16'hFF0F) begin
                            iof[7'h0F] <= r_in.wdata | 8'hE0;
                        end else if (w_a >= 16'hFF40 && w_a <= 16'hFF4B &&
                                     w_a != 16'hFF46) begin
                            r_out.target    <= TGT_VIDEO;
                            r_out.ext_write <= 1'b1;
                            r_out.ext_wdata <= r_in.wdata;
                        end else if (w_a != 16'hFF50) begin
                            iof[w_a[6:0]] <= r_in.wdata;
                        end
                    end
                end
                ACT_TICK: begin
                    if (w_cp) begin
                        if (32'(r_dma_idx) < ObjBytes) oam[r_dma_idx] <= w_byte;
                        r_out.rdata      <= w_byte;
                        r_out.target     <= r_dec.tgt;
                        r_out.dma_copied <= 1'b1;
                    end
                end
                ACT_LOAD: begin
                    if (32'(w_a) < BootBytes && w_a < 16'd256)
                        boot[w_a[7:0]] <= r_in.wdata;
                end
                default: ;
            endcase
            r_out.dma_busy         <= w_nact;
            r_out.dma_next_address <= w_nact ? {w_npage, w_nidx} : 16'h0000;
            r_out.dma_next_target  <= w_nact ? w_ndec.tgt : TGT_INT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= 14'd0;
            r_boot_en  <= 1'b1;
            r_ie       <= 8'h00;
            r_dma_act  <= 1'b0;
            r_dma_page <= 8'h00;
            r_dma_idx  <= 8'h00;
            r_dma_ph   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 14'd1;
            if (r_state == ST_EXEC) begin
                r_dma_act  <= w_nact;
                r_dma_page <= w_npage;
                r_dma_idx  <= w_nidx;
                if (r_in.action == ACT_WRITE) begin
                    if (w_a == 16'hFF50) r_boot_en <= 1'b0;
                    if (w_a == 16'hFFFF) r_ie <= r_in.wdata;
                end
                if (r_in.action == ACT_TICK && r_dma_act) begin
                    // advance the phase; a copy or the end of the copy drops it to zero
                    r_dma_ph <= (w_cp || !w_nact) ? 2'd0 : r_dma_ph + 2'd1;
                end
            end
        end
    end
endmodule
`default_nettype wire
